// ----- rtl/msb_first_bit_packer_unit_defines.svh -----
// Assertion macros used by the bit packer top level.
`ifndef MSB_FIRST_BIT_PACKER_UNIT_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MSBP_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msbp: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define MSBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msbp: next-cycle check failed");

`endif

// ----- rtl/msbp_pkg.sv -----
// Types, codes and constants of the MSB-first bit packer.
package msbp_pkg;

   localparam int POS_W            = 13;
   localparam int VALUE_W          = 32;
   localparam int COUNT_W          = 6;
   localparam int SIZE_W           = 10;
   localparam int MAX_FIELD_BITS   = 32;
   localparam int DEF_BUFFER_BYTES = 512;

   localparam logic [1:0] OP_APPEND  = 2'd0;
   localparam logic [1:0] OP_EXTRACT = 2'd1;
   localparam logic [1:0] OP_SETPOS  = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [VALUE_W-1:0] field_value;
      logic [COUNT_W-1:0] bit_count;
      logic [POS_W-1:0]   new_write_position;
   } msbp_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic [POS_W-1:0]   write_position;
      logic [POS_W-1:0]   read_position;
      logic [SIZE_W-1:0]  size_bytes;
      logic               fault;
   } msbp_rsp_type;

   // Control from the sequencer to the bit lane.
   typedef struct packed {
      logic       start;       // load value, clear extracted bits
      logic       load;        // capture byte from the store
      logic       apply_trim;  // zero the bits past the write position on load
      logic [2:0] trim_bits;   // bits kept in the trimmed byte
      logic       put;         // insert one value bit into the byte
      logic       get;         // shift one byte bit into the read value
      logic [2:0] bit_sel;     // bit offset within the byte, 0 is the MSB
   } msbp_lane_ctrl_type;

   // Keep the top used bits of a byte, zero the rest.
   function automatic logic [7:0] trim_mask(input logic [2:0] used);
      trim_mask = ~(8'hFF >> used);
   endfunction

endpackage

// ----- rtl/msbp_ram.sv -----
// Generic simple dual-port RAM with registered read.
module msbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/msbp_bit_lane.sv -----
// Bit lane: byte register and value shift registers; one bit per put or get cycle.
module msbp_bit_lane
   import msbp_pkg::*;
(
   input  logic               clock,
   input  msbp_lane_ctrl_type ctrl,
   input  logic [VALUE_W-1:0] field_value,
   input  logic [7:0]         rd_byte,
   output logic [7:0]         wr_byte,
   output logic [VALUE_W-1:0] read_value
);

   logic [VALUE_W-1:0] val_ff, val_in;
   logic [VALUE_W-1:0] rv_ff, rv_in;
   logic [7:0]         byte_ff, byte_in;

   always_comb begin
      val_in  = val_ff;
      rv_in   = rv_ff;
      byte_in = byte_ff;
      if (ctrl.start) begin
         val_in = field_value;
         rv_in  = '0;
      end
      if (ctrl.load) begin
         byte_in = ctrl.apply_trim ? (rd_byte & trim_mask(ctrl.trim_bits)) : rd_byte;
      end
      // Append walks the field from its last bit backward: take the LSB, shift right.
      if (ctrl.put) begin
         byte_in[~ctrl.bit_sel] = val_ff[0];
         val_in = {1'b0, val_ff[VALUE_W-1:1]};
      end
      if (ctrl.get) begin
         rv_in = {rv_ff[VALUE_W-2:0], byte_ff[~ctrl.bit_sel]};
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rv_ff   <= rv_in;
      byte_ff <= byte_in;
   end

   assign wr_byte    = byte_ff;
   assign read_value = rv_ff;

endmodule

// ----- rtl/msb_first_bit_packer_unit.sv -----
// Top level of the MSB-first bit packer: sequencer, positions and byte store.
// Usage:
//   Present a word on req_word and raise start; it is taken at a rising edge
//   with start high and busy low. Each word yields one result word on rsp_word,
//   shown for exactly one cycle with rsp_valid high. The receiver cannot stall.
//   Opcodes: append, extract, set write position, clear all.
// Sequence from accept to the result (a field touches at most 5 bytes):
//   append of n bits:        per byte read, load, bit steps, write; then done
//   extract of n bits:       per byte read, load, bit steps; then done
//   set write position:      read, load, write if the last byte is partial; then done
//   faulting word:           done
//   clear all:               a sweep of all BUFFER_BYTES bytes, then done
//   Appends pass each byte through the single-byte store port as a
//   read-modify-write, and the bit lane moves one bit per cycle in the bit steps.
//   A new word is accepted in the same cycle as the previous result is shown.
// Reset: both positions return to zero and a sweep over all BUFFER_BYTES bytes
//   zeroes the store; busy stays high during the sweep and no result is given.
// Faults: bad bit count or position sets fault and changes nothing.
`include "msb_first_bit_packer_unit_defines.svh"

module msb_first_bit_packer_unit
   import msbp_pkg::*;
#(
   parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  msbp_req_type req_word,
   output logic         rsp_valid,
   output msbp_rsp_type rsp_word
);

   localparam int ADDR_W = $clog2(BUFFER_BYTES);
   localparam logic [POS_W:0]    TOTAL_BITS = (POS_W+1)'(BUFFER_BYTES * 8);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(BUFFER_BYTES - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_BIT   = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [POS_W-1:0]   ptr_ff, ptr_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0]         trim_ff, trim_in;
   logic               first_ff, first_in;
   logic               fault_ff, fault_in;
   logic [POS_W-1:0]   wpos_ff, wpos_in;
   logic [POS_W-1:0]   rpos_ff, rpos_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   msbp_rsp_type       rsp_word_ff, rsp_word_in;

   msbp_lane_ctrl_type lane_ctrl;
   logic [7:0]         lane_byte;
   logic [VALUE_W-1:0] lane_value;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [7:0]         ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [7:0]         ram_rdata;

   logic               accept;
   logic               count_ok;
   logic [POS_W:0]     sum_w;
   logic [POS_W:0]     sum_r;
   logic [POS_W:0]     size_sum;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign count_ok = (req_word.bit_count != '0) &&
                     (req_word.bit_count <= COUNT_W'(MAX_FIELD_BITS));
   assign sum_w    = (POS_W+1)'(wpos_ff) + (POS_W+1)'(req_word.bit_count);
   assign sum_r    = (POS_W+1)'(rpos_ff) + (POS_W+1)'(req_word.bit_count);
   assign size_sum = (POS_W+1)'(wpos_ff) + (POS_W+1)'(7);

   // Reads always follow the byte under the bit pointer.
   assign ram_raddr = ptr_ff[ADDR_W+2:3];
   assign ram_we    = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : addr_ff;
   assign ram_wdata = (state_ff == ST_CLEAR) ? 8'h00 : lane_byte;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      trim_in      = trim_ff;
      first_in     = first_ff;
      fault_in     = fault_ff;
      wpos_in      = wpos_ff;
      rpos_in      = rpos_ff;
      clr_addr_in  = clr_addr_ff;
      clr_rsp_in   = clr_rsp_ff;
      addr_in      = addr_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      lane_ctrl    = '0;
      lane_ctrl.bit_sel   = ptr_ff[2:0];
      lane_ctrl.trim_bits = trim_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_word.opcode;
               fault_in = 1'b0;
               first_in = 1'b0;
               lane_ctrl.start = 1'b1;
               case (req_word.opcode)
                  OP_APPEND: begin
                     if (!count_ok || (sum_w > TOTAL_BITS)) begin
                        fault_in = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        // Write backward from the last bit; its byte is also the tail byte.
                        ptr_in   = POS_W'(sum_w - (POS_W+1)'(1));
                        cnt_in   = req_word.bit_count;
                        trim_in  = sum_w[2:0];
                        first_in = 1'b1;
                        wpos_in  = sum_w[POS_W-1:0];
                        state_in = ST_READ;
                     end
                  end
                  OP_EXTRACT: begin
                     if (!count_ok || (sum_r > TOTAL_BITS) ||
                         (sum_r > (POS_W+1)'(wpos_ff))) begin
                        fault_in = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        ptr_in   = rpos_ff;
                        cnt_in   = req_word.bit_count;
                        rpos_in  = sum_r[POS_W-1:0];
                        state_in = ST_READ;
                     end
                  end
                  OP_SETPOS: begin
                     if ({1'b0, req_word.new_write_position} > TOTAL_BITS) begin
                        fault_in = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        wpos_in = req_word.new_write_position;
                        if (rpos_ff > req_word.new_write_position) begin
                           rpos_in = req_word.new_write_position;
                        end
                        if (req_word.new_write_position[2:0] != 3'd0) begin
                           ptr_in   = req_word.new_write_position;
                           trim_in  = req_word.new_write_position[2:0];
                           first_in = 1'b1;
                           state_in = ST_READ;
                        end else begin
                           state_in = ST_DONE;
                        end
                     end
                  end
                  default: begin
                     wpos_in     = '0;
                     rpos_in     = '0;
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = ST_CLEAR;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               clr_rsp_in = 1'b0;
               state_in   = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_READ: begin
            addr_in  = ptr_ff[ADDR_W+2:3];
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            lane_ctrl.load       = 1'b1;
            lane_ctrl.apply_trim = first_ff && (trim_ff != 3'd0);
            first_in = 1'b0;
            state_in = (op_ff == OP_SETPOS) ? ST_WRITE : ST_BIT;
         end
         ST_BIT: begin
            cnt_in = cnt_ff - COUNT_W'(1);
            if (op_ff == OP_APPEND) begin
               lane_ctrl.put = 1'b1;
               ptr_in = ptr_ff - POS_W'(1);
               // Flush the byte once its MSB is done or the field runs out.
               if ((cnt_ff == COUNT_W'(1)) || (ptr_ff[2:0] == 3'd0)) begin
                  state_in = ST_WRITE;
               end
            end else begin
               lane_ctrl.get = 1'b1;
               ptr_in = ptr_ff + POS_W'(1);
               if (cnt_ff == COUNT_W'(1)) begin
                  state_in = ST_DONE;
               end else if (ptr_ff[2:0] == 3'd7) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_WRITE: begin
            if ((op_ff == OP_SETPOS) || (cnt_ff == '0)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            rsp_valid_in               = 1'b1;
            rsp_word_in.read_value     = lane_value;
            rsp_word_in.write_position = wpos_ff;
            rsp_word_in.read_position  = rpos_ff;
            rsp_word_in.size_bytes     = size_sum[SIZE_W+2:3];
            rsp_word_in.fault          = fault_ff;
            state_in                   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wpos_ff      <= '0;
         rpos_ff      <= '0;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         rpos_ff      <= rpos_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ptr_ff      <= ptr_in;
      cnt_ff      <= cnt_in;
      trim_ff     <= trim_in;
      first_ff    <= first_in;
      fault_ff    <= fault_in;
      addr_ff     <= addr_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   msbp_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   msbp_bit_lane u_lane (
      .clock       (clock),
      .ctrl        (lane_ctrl),
      .field_value (req_word.field_value),
      .rd_byte     (ram_rdata),
      .wr_byte     (lane_byte),
      .read_value  (lane_value)
   );

   // A result strobe is never raised back to back.
   `MSBP_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   // Every accepted word keeps the unit busy in the next cycle.
   `MSBP_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   // The read position never passes the write position.
   `MSBP_ASSERT_HOLDS(a_rd_le_wr, clock, reset, 1'b1, rpos_ff <= wpos_ff)
   // A shown result reports the live positions.
   `MSBP_ASSERT_HOLDS(a_rsp_pos, clock, reset, rsp_valid_ff,
      (rsp_word_ff.write_position == wpos_ff) && (rsp_word_ff.read_position == rpos_ff))

endmodule

// ----- verif/msb_first_bit_packer_unit_tb.sv -----
// Self-checking testbench of the MSB-first bit packer: directed cases, then random traffic.
`timescale 1ns / 100ps

module msb_first_bit_packer_unit_tb;
   import msbp_pkg::*;

   localparam int unsigned TOTAL_BITS  = DEF_BUFFER_BYTES * 8;
   localparam int unsigned RANDOM_WORDS = 800;
   // Longest quiet time after the last result: a clear sweep plus margin.
   localparam int unsigned DRAIN_CYCLES = DEF_BUFFER_BYTES + 100;
   // Worst run: every word a clear sweep plus the longest sender gap, taken
   // several times over.
   localparam int unsigned TIMEOUT_NS   = 60_000_000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   msbp_req_type req_word = '0;
   logic         rsp_valid;
   msbp_rsp_type rsp_word;

   // Shadow of the packer: byte store and both bit positions.
   logic [7:0]   shadow_bytes [DEF_BUFFER_BYTES];
   int unsigned  shadow_wr_pos;
   int unsigned  shadow_rd_pos;

   msbp_rsp_type expected_results [$];

   int unsigned  error_count     = 0;
   int unsigned  words_taken     = 0;
   int unsigned  results_checked = 0;
   int unsigned  faults_seen     = 0;
   int unsigned  clears_taken    = 0;
   bit           idle_enabled    = 1'b1;

   msb_first_bit_packer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Build one request word; unused fields still carry whatever is passed.
   function automatic msbp_req_type make_word(input logic [1:0] op, input int unsigned val,
                                              input int unsigned n, input int unsigned pos);
      msbp_req_type w;
      w.opcode             = op;
      w.field_value        = VALUE_W'(val);
      w.bit_count          = COUNT_W'(n);
      w.new_write_position = POS_W'(pos);
      return w;
   endfunction

   // Advance the shadow by one word and return the result it should produce.
   function automatic msbp_rsp_type predict_packer(input msbp_req_type w);
      msbp_rsp_type r;
      int unsigned  n;
      int unsigned  b;
      int unsigned  used;
      logic [31:0]  rv;
      logic         fault;
      n     = w.bit_count;
      rv    = '0;
      fault = 1'b0;
      case (w.opcode)
         OP_APPEND: begin
            if (n < 1 || n > MAX_FIELD_BITS || shadow_wr_pos + n > TOTAL_BITS) begin
               fault = 1'b1;
            end else begin
               // Store the low n bits, highest first.
               for (int i = 0; i < n; i++) begin
                  b = shadow_wr_pos + i;
                  shadow_bytes[b >> 3][7 - (b % 8)] = w.field_value[n - 1 - i];
               end
               shadow_wr_pos += n;
            end
         end
         OP_EXTRACT: begin
            if (n < 1 || n > MAX_FIELD_BITS || shadow_rd_pos + n > TOTAL_BITS ||
                shadow_rd_pos + n > shadow_wr_pos) begin
               fault = 1'b1;
            end else begin
               for (int i = 0; i < n; i++) begin
                  b  = shadow_rd_pos + i;
                  rv = {rv[30:0], shadow_bytes[b >> 3][7 - (b % 8)]};
               end
               shadow_rd_pos += n;
            end
         end
         OP_SETPOS: begin
            if (w.new_write_position > TOTAL_BITS) begin
               fault = 1'b1;
            end else begin
               shadow_wr_pos = w.new_write_position;
               // Pull the read position down to the new write position.
               if (shadow_rd_pos > shadow_wr_pos) begin
                  shadow_rd_pos = shadow_wr_pos;
               end
            end
         end
         default: begin
            for (int i = 0; i < DEF_BUFFER_BYTES; i++) begin
               shadow_bytes[i] = '0;
            end
            shadow_wr_pos = 0;
            shadow_rd_pos = 0;
         end
      endcase
      // Zero the bits of a partly used last byte beyond the write position.
      if (!fault && (w.opcode == OP_APPEND || w.opcode == OP_SETPOS)) begin
         used = shadow_wr_pos % 8;
         b    = shadow_wr_pos >> 3;
         if (used != 0 && b < DEF_BUFFER_BYTES) begin
            shadow_bytes[b] &= 8'(8'hFF << (8 - used));
         end
      end
      r.read_value     = rv;
      r.write_position = POS_W'(shadow_wr_pos);
      r.read_position  = POS_W'(shadow_rd_pos);
      r.size_bytes     = SIZE_W'((shadow_wr_pos + 7) >> 3);
      r.fault          = fault;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Check the result shown in this cycle, then record the word taken in this
   // cycle. Both read values from before the edge, so driver order is moot.
   always @(posedge clock) begin : result_checker
      msbp_rsp_type exp_word;
      if (reset) begin
         for (int i = 0; i < DEF_BUFFER_BYTES; i++) begin
            shadow_bytes[i] = '0;
         end
         shadow_wr_pos = 0;
         shadow_rd_pos = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result word %h shown with none expected", $time, rsp_word);
               error_count++;
            end else begin
               exp_word = expected_results.pop_front();
               check_field("read_value", exp_word.read_value, rsp_word.read_value);
               check_field("write_position", 32'(exp_word.write_position),
                           32'(rsp_word.write_position));
               check_field("read_position", 32'(exp_word.read_position),
                           32'(rsp_word.read_position));
               check_field("size_bytes", 32'(exp_word.size_bytes), 32'(rsp_word.size_bytes));
               check_field("fault", 32'(exp_word.fault), 32'(rsp_word.fault));
               results_checked++;
               if (exp_word.fault) begin
                  faults_seen++;
               end
            end
         end
         if (start && busy === 1'b0) begin
            expected_results.push_back(predict_packer(req_word));
            words_taken++;
            if (req_word.opcode == OP_CLEAR) begin
               clears_taken++;
            end
         end
      end
   end

   // Send one word: present it, hold start low at random with a chance of 29 in a
   // hundred, and wait for the edge that takes it. Start is high on return so the
   // next word can follow back to back.
   task automatic send_word(input msbp_req_type w);
      logic taken;
      taken    = 1'b0;
      req_word <= w;
      while (!taken) begin
         start <= !(idle_enabled && $urandom_range(99) < 29);
         @(posedge clock);
         taken = start && (busy === 1'b0);
      end
   endtask

   // Illegal counts on both bit operations, and an extract from an empty stream.
   task automatic test_bad_counts();
      send_word(make_word(OP_APPEND, 32'hFFFF_FFFF, 0, $urandom));
      send_word(make_word(OP_APPEND, 32'hFFFF_FFFF, 63, $urandom));
      send_word(make_word(OP_EXTRACT, $urandom, 0, $urandom));
      send_word(make_word(OP_EXTRACT, $urandom, 33, $urandom));
      send_word(make_word(OP_EXTRACT, $urandom, 1, $urandom));
   endtask

   // Full and single-bit fields, a partial byte, then reads up to and past
   // the write position.
   task automatic test_append_extract();
      send_word(make_word(OP_APPEND, 32'hFFFF_FFFF, 32, 0));
      send_word(make_word(OP_APPEND, 32'hFFFF_FFFE, 1, 0));
      send_word(make_word(OP_APPEND, 32'h0000_0055, 7, 0));
      send_word(make_word(OP_EXTRACT, 0, 32, 0));
      send_word(make_word(OP_EXTRACT, 0, 8, 0));
      send_word(make_word(OP_EXTRACT, 0, 1, 0));
   endtask

   // Positions past the end, a rewind below the read position, and a return
   // to zero.
   task automatic test_set_position();
      send_word(make_word(OP_SETPOS, $urandom, $urandom, TOTAL_BITS + 1));
      send_word(make_word(OP_SETPOS, $urandom, $urandom, 13'h1FFF));
      send_word(make_word(OP_SETPOS, $urandom, $urandom, 4));
      send_word(make_word(OP_APPEND, 32'h0000_000F, 4, 0));
      send_word(make_word(OP_EXTRACT, 0, 4, 0));
      send_word(make_word(OP_SETPOS, $urandom, $urandom, 0));
   endtask

   // Fill the stream to the last bit, overrun it, and park at the end.
   task automatic test_buffer_end();
      send_word(make_word(OP_SETPOS, 0, 0, TOTAL_BITS - 32));
      send_word(make_word(OP_APPEND, 32'hA5A5_A5A5, 32, 0));
      send_word(make_word(OP_APPEND, 32'hFFFF_FFFF, 1, 0));
      send_word(make_word(OP_EXTRACT, 0, 32, 0));
      send_word(make_word(OP_SETPOS, 0, 0, TOTAL_BITS));
   endtask

   // Clear everything and show the stream is empty again.
   task automatic test_clear_all();
      send_word(make_word(OP_CLEAR, $urandom, $urandom, $urandom));
      send_word(make_word(OP_EXTRACT, 0, 1, 0));
      send_word(make_word(OP_APPEND, 32'h0000_0013, 5, 0));
   endtask

   // Mostly legal traffic so the stream fills, drains and rewinds, with some
   // illegal counts, bad positions and rare clears mixed in.
   task automatic test_random_traffic(input int unsigned count);
      msbp_req_type w;
      int unsigned  roll;
      int unsigned  avail;
      int unsigned  lim;
      for (int k = 0; k < count; k++) begin
         // Run a long stretch back to back.
         idle_enabled = !(k >= count / 3 && k < count / 3 + 200);
         w     = make_word(OP_APPEND, $urandom, $urandom_range(1, 32), $urandom);
         roll  = $urandom_range(99);
         avail = shadow_wr_pos - shadow_rd_pos;
         if (roll < 42) begin
            // keep the legal append built above
         end else if (roll < 72) begin
            w.opcode = OP_EXTRACT;
            lim      = (avail < 32) ? avail : 32;
            if (lim >= 1 && $urandom_range(9) < 8) begin
               w.bit_count = COUNT_W'($urandom_range(1, lim));
            end
         end else if (roll < 84) begin
            w.opcode = OP_SETPOS;
            case ($urandom_range(9))
               0, 1, 2, 3, 4: w.new_write_position = POS_W'($urandom_range(0, shadow_wr_pos));
               5, 6, 7:       w.new_write_position = POS_W'($urandom_range(0, TOTAL_BITS));
               default:       w.new_write_position =
                                 POS_W'($urandom_range(TOTAL_BITS - 96, TOTAL_BITS));
            endcase
         end else if (roll < 90) begin
            w.opcode             = OP_SETPOS;
            w.new_write_position = POS_W'($urandom_range(TOTAL_BITS + 1, 13'h1FFF));
         end else if (roll < 97) begin
            w.opcode    = $urandom_range(1) ? OP_APPEND : OP_EXTRACT;
            w.bit_count = $urandom_range(1) ? COUNT_W'(0) : COUNT_W'($urandom_range(33, 63));
         end else begin
            w.opcode = OP_CLEAR;
         end
         send_word(w);
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      // Hold reset, then release it; the block then sweeps its store while busy.
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_bad_counts();
      test_append_extract();
      test_set_position();
      test_buffer_end();
      test_clear_all();
      test_random_traffic(RANDOM_WORDS);

      // Drop start at the edge that took the last word.
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d words (%0d clears), checked %0d results, %0d of them faults.",
               words_taken, clears_taken, results_checked, faults_seen);
      $display("Cases: bad counts, full and partial fields, rewinds, end of store, clears.");
      if (error_count == 0) begin
         $display("msb_first_bit_packer_unit_tb passed");
      end else begin
         $display("msb_first_bit_packer_unit_tb failed");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("msb_first_bit_packer_unit_tb failed");
      $finish;
   end

endmodule

// ----- msb_first_bit_packer_unit.f -----
+incdir+rtl
rtl/msbp_pkg.sv
rtl/msbp_ram.sv
rtl/msbp_bit_lane.sv
rtl/msb_first_bit_packer_unit.sv
verif/msb_first_bit_packer_unit_tb.sv
